[rtl/oaht_pkg.sv]
// package for the open-addressing hash table
// codes, field widths and the controller/datapath command and status structs
package oaht_pkg;

	localparam int KEY_BITS       = 31;
	localparam int CNT_BITS       = 6;
	localparam int SIZE_BITS      = 6;
	localparam int MODE_BITS      = 2;
	localparam int OP_BITS        = 2;
	localparam int STATUS_BITS    = 2;
	localparam int FOUND_BITS     = 32;
	localparam int CFG_DATA_BITS  = 6;
	localparam int MAX_SLOTS_DEF  = 32;
	localparam int VALUE_BITS_DEF = 32;

	localparam logic [SIZE_BITS-1:0] SIZE_RESET = 6'd20;

	localparam logic [0:0] CFG_PROBE_MODE = 1'b0;
	localparam logic [0:0] CFG_TABLE_SIZE = 1'b1;

	localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OP_BITS-1:0] OP_DELETE = 2'd2;

	localparam logic [MODE_BITS-1:0] MODE_LINEAR    = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_QUADRATIC = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_DOUBLE    = 2'd2;

	localparam logic [1:0] MARK_EMPTY    = 2'd0;
	localparam logic [1:0] MARK_DELETED  = 2'd1;
	localparam logic [1:0] MARK_OCCUPIED = 2'd2;

	localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_INIT,
		S_READ,
		S_CHECK,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic                   load;
		logic                   mod_step;
		logic                   probe_init;
		logic                   read;
		logic                   advance;
		logic                   wr_ins;
		logic                   wr_del;
		logic                   set_res;
		logic                   take_val;
		logic [STATUS_BITS-1:0] res_status;
		logic                   emit;
	} cmd_t;

	typedef struct packed {
		logic               mod_last;
		logic [OP_BITS-1:0] op;
		logic [1:0]         mark;
		logic               key_hit;
		logic               last_probe;
		logic               out_free;
	} stat_t;

endpackage

[rtl/oaht_req_if.sv]
// request channel of the hash table: operation, key and value
// depends on oaht_pkg for field widths
interface oaht_req_if #(
	parameter int VALUE_BITS = oaht_pkg::VALUE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic [oaht_pkg::OP_BITS-1:0]  operation;
	logic [oaht_pkg::KEY_BITS-1:0] key;
	logic [VALUE_BITS-1:0]         value;

	modport source (output valid, operation, key, value, input ready);
	modport sink (input valid, operation, key, value, output ready);
endinterface

[rtl/oaht_rsp_if.sv]
// response channel of the hash table: status, found value and entry count
// depends on oaht_pkg for field widths
interface oaht_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [oaht_pkg::STATUS_BITS-1:0] status;
	logic [oaht_pkg::FOUND_BITS-1:0]  found_value;
	logic [oaht_pkg::CNT_BITS-1:0]    entry_count;

	modport source (output valid, status, found_value, entry_count, input ready);
	modport sink (input valid, status, found_value, entry_count, output ready);
endinterface

[rtl/oaht_ctrl.sv]
// controller state machine for the hash table
// depends on oaht_pkg; drives commands to oaht_dp and reads its status
module oaht_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  oaht_pkg::stat_t st,
	output oaht_pkg::cmd_t  cmd
);
	import oaht_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MOD;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (st.mod_last) begin
					state_d = S_INIT;
				end
			end
			S_INIT: begin
				cmd.probe_init = 1'b1;
				if (st.op inside {OP_INSERT, OP_LOOKUP, OP_DELETE}) begin
					state_d = S_READ;
				end else begin
					// unknown operation: nothing changes
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_OK;
					state_d        = S_RESULT;
				end
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_d  = S_CHECK;
			end
			S_CHECK: begin
				if (st.op == OP_INSERT) begin
					if (st.mark != MARK_OCCUPIED) begin
						cmd.wr_ins     = 1'b1;
						cmd.set_res    = 1'b1;
						cmd.res_status = ST_OK;
						state_d        = S_RESULT;
					end else if (st.last_probe) begin
						cmd.set_res    = 1'b1;
						cmd.res_status = ST_FULL;
						state_d        = S_RESULT;
					end else begin
						cmd.advance = 1'b1;
						state_d     = S_READ;
					end
				end else begin
					if (st.mark == MARK_EMPTY) begin
						cmd.set_res    = 1'b1;
						cmd.res_status = ST_NOT_FOUND;
						state_d        = S_RESULT;
					end else if (st.mark == MARK_OCCUPIED && st.key_hit) begin
						cmd.set_res    = 1'b1;
						cmd.res_status = ST_OK;
						cmd.take_val   = (st.op == OP_LOOKUP);
						cmd.wr_del     = (st.op == OP_DELETE);
						state_d        = S_RESULT;
					end else if (st.last_probe) begin
						cmd.set_res    = 1'b1;
						cmd.res_status = ST_NOT_FOUND;
						state_d        = S_RESULT;
					end else begin
						cmd.advance = 1'b1;
						state_d     = S_READ;
					end
				end
			end
			S_RESULT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[rtl/oaht_dp.sv]
// datapath of the hash table: config registers, key mod unit, probe index,
// slot memories, slot marks, entry count and output register; depends on oaht_pkg
module oaht_dp #(
	parameter int MAX_SLOTS  = oaht_pkg::MAX_SLOTS_DEF,
	parameter int VALUE_BITS = oaht_pkg::VALUE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [0:0]                          cfg_index,
	input  logic [oaht_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic [oaht_pkg::OP_BITS-1:0]        in_operation,
	input  logic [oaht_pkg::KEY_BITS-1:0]       in_key,
	input  logic [VALUE_BITS-1:0]               in_value,
	input  oaht_pkg::cmd_t                      cmd,
	output oaht_pkg::stat_t                     st,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [oaht_pkg::STATUS_BITS-1:0]    out_status,
	output logic [oaht_pkg::FOUND_BITS-1:0]     out_found_value,
	output logic [oaht_pkg::CNT_BITS-1:0]       out_entry_count
);
	import oaht_pkg::*;

	localparam int AW       = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int SIZE_CAP = (MAX_SLOTS < 63) ? MAX_SLOTS : 63;
	localparam int BIT_W    = $clog2(KEY_BITS);

	logic [MODE_BITS-1:0]  mode_q;
	logic [SIZE_BITS-1:0]  size_q;
	logic [SIZE_BITS-1:0]  n;
	logic [OP_BITS-1:0]    op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [BIT_W-1:0]      bit_q;
	logic [SIZE_BITS-1:0]  rem_q;
	logic [SIZE_BITS:0]    rem_try;
	logic [SIZE_BITS-1:0]  rem_next;
	logic [SIZE_BITS-1:0]  slot_q;
	logic [SIZE_BITS-1:0]  step_q;
	logic [SIZE_BITS-1:0]  probe_q;
	logic [SIZE_BITS-1:0]  inc;
	logic [SIZE_BITS-1:0]  one_mod;
	logic [AW-1:0]         addr;
	logic [KEY_BITS-1:0]   key_mem [MAX_SLOTS];
	logic [VALUE_BITS-1:0] val_mem [MAX_SLOTS];
	logic [1:0]            marks_q [MAX_SLOTS];
	logic [KEY_BITS-1:0]   rd_key_q;
	logic [VALUE_BITS-1:0] rd_val_q;
	logic [1:0]            rd_mark_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [STATUS_BITS-1:0] res_status_q;
	logic [FOUND_BITS-1:0]  res_val_q;
	logic                   out_valid_q;
	logic [STATUS_BITS-1:0] out_status_q;
	logic [FOUND_BITS-1:0]  out_found_q;
	logic [CNT_BITS-1:0]    out_cnt_q;

	// (a + b) mod n for a < n and b up to max(n, 2)
	function automatic logic [SIZE_BITS-1:0] add_mod(
		input logic [SIZE_BITS-1:0] a,
		input logic [SIZE_BITS-1:0] b,
		input logic [SIZE_BITS-1:0] m
	);
		logic [SIZE_BITS:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= {1'b0, m}) begin
			sum = sum - {1'b0, m};
		end
		if (sum >= {1'b0, m}) begin
			sum = sum - {1'b0, m};
		end
		return sum[SIZE_BITS-1:0];
	endfunction

	always_comb begin
		if (size_q == '0) begin
			n = SIZE_BITS'(1);
		end else if (size_q > SIZE_BITS'(SIZE_CAP)) begin
			n = SIZE_BITS'(SIZE_CAP);
		end else begin
			n = size_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LINEAR;
			size_q <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PROBE_MODE: mode_q <= cfg_data[MODE_BITS-1:0];
				CFG_TABLE_SIZE: size_q <= cfg_data[SIZE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// restoring remainder, one key bit per cycle from the top
	assign rem_try  = {rem_q, key_q[bit_q]};
	assign rem_next = (rem_try >= {1'b0, n}) ? SIZE_BITS'(rem_try - {1'b0, n})
	                                         : rem_try[SIZE_BITS-1:0];
	assign one_mod  = (n == SIZE_BITS'(1)) ? '0 : SIZE_BITS'(1);

	always_comb begin
		case (mode_q)
			MODE_QUADRATIC: inc = step_q;
			MODE_DOUBLE:    inc = key_q[0] ? SIZE_BITS'(1) : SIZE_BITS'(2);
			default:        inc = SIZE_BITS'(1);
		endcase
	end

	assign addr = AW'(slot_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_operation;
			key_q <= in_key;
			val_q <= in_value;
			bit_q <= BIT_W'(KEY_BITS - 1);
			rem_q <= '0;
		end
		if (cmd.mod_step) begin
			rem_q <= rem_next;
			bit_q <= bit_q - BIT_W'(1);
		end
		if (cmd.probe_init) begin
			slot_q  <= rem_q;
			step_q  <= one_mod;
			probe_q <= '0;
		end
		if (cmd.advance) begin
			slot_q  <= add_mod(slot_q, inc, n);
			step_q  <= add_mod(step_q, SIZE_BITS'(2), n);
			probe_q <= probe_q + SIZE_BITS'(1);
		end
		if (cmd.read) begin
			rd_key_q  <= key_mem[addr];
			rd_val_q  <= val_mem[addr];
			rd_mark_q <= marks_q[addr];
		end
		if (cmd.wr_ins) begin
			key_mem[addr] <= key_q;
			val_mem[addr] <= val_q;
		end
		if (cmd.set_res) begin
			res_status_q <= cmd.res_status;
			res_val_q    <= cmd.take_val ? FOUND_BITS'(rd_val_q) : '0;
		end
		if (cmd.emit) begin
			out_status_q <= res_status_q;
			out_found_q  <= res_val_q;
			out_cnt_q    <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SLOTS; i++) begin
				marks_q[i] <= MARK_EMPTY;
			end
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wr_ins) begin
				marks_q[addr] <= MARK_OCCUPIED;
				cnt_q         <= cnt_q + CNT_BITS'(1);
			end else if (cmd.wr_del) begin
				marks_q[addr] <= MARK_DELETED;
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - CNT_BITS'(1);
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		st            = '0;
		st.mod_last   = (bit_q == '0);
		st.op         = op_q;
		st.mark       = rd_mark_q;
		st.key_hit    = (rd_key_q == key_q);
		st.last_probe = (probe_q == n - SIZE_BITS'(1));
		st.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid       = out_valid_q;
	assign out_status      = out_status_q;
	assign out_found_value = out_found_q;
	assign out_entry_count = out_cnt_q;

endmodule

[rtl/open_addressing_hash_table_top.sv]
// open-addressing hash table: insert, lookup and delete with linear, quadratic
// or double-hash probing. an item takes p probes (1 to table size, 0 for an unknown operation)
// and runs through bit-serial key mod size, one setup, per probe a slot memory read, then
// a compare, and last the move into the output register, which waits while a held result is unread.
// one item in flight: no new item is taken until its result is in the output register
// reset marks every slot empty, count zero, probe mode linear, size 20; no clearing pass
module open_addressing_hash_table_top #(
	parameter int MAX_SLOTS  = oaht_pkg::MAX_SLOTS_DEF,
	parameter int VALUE_BITS = oaht_pkg::VALUE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [0:0]                         cfg_index,
	input  logic [oaht_pkg::CFG_DATA_BITS-1:0] cfg_data,
	oaht_req_if.sink                           req,
	oaht_rsp_if.source                         rsp
);
	import oaht_pkg::*;

	cmd_t  cmd;
	stat_t st;
	logic  in_ready;

	oaht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	oaht_dp #(
		.MAX_SLOTS  (MAX_SLOTS),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_operation    (req.operation),
		.in_key          (req.key),
		.in_value        (req.value),
		.cmd             (cmd),
		.st              (st),
		.out_valid       (rsp.valid),
		.out_ready       (rsp.ready),
		.out_status      (rsp.status),
		.out_found_value (rsp.found_value),
		.out_entry_count (rsp.entry_count)
	);

	assign req.ready = in_ready;

endmodule
